// ===== src/circular_queue_buffer_macros.svh =====
`ifndef CIRCULAR_QUEUE_BUFFER_MACROS_SVH
`define CIRCULAR_QUEUE_BUFFER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CQB_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("circular_queue_buffer: invariant violated");

// Check that a condition holds in the cycle after a trigger.
`define CQB_ASSERT_NEXT(lbl, trig, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error("circular_queue_buffer: sequence violated");

`endif

// ===== src/cqb_pkg.sv =====
`default_nettype none

package cqb_pkg;

	localparam int WORD_W      = 32;
	localparam int LEN_W       = 5;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_SHOW = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_VALUE  = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== src/cqb_ram.sv =====
`default_nettype none

module cqb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/circular_queue_buffer.sv =====
// Push and empty results are registered at the output from S_RES, popped words from S_DATA.
// Push and pop return to S_IDLE once their result is loaded; a show streams its words
// through the single read port of the slot memory, one word per cycle while the output is free.
// Output stalls hold the sequencer; a new request is taken once its result is registered.
// Reset (arst_n low): queue empty, head and tail at slot 0, length 16; slot memory not cleared.
`default_nettype none

`include "circular_queue_buffer_macros.svh"

module circular_queue_buffer import cqb_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               action,
	input  wire logic signed [WORD_W-1:0] push_value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic signed [WORD_W-1:0]      value,
	output logic                          last,
	input  wire logic                     cfg_we,
	input  wire logic [LEN_W-1:0]         cfg_wdata
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP   = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
	localparam int CW    = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RES,
		S_DATA
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  head_q, tail_q, ptr_q;
	logic              empty_q;
	logic [LEN_W-1:0]  length_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              last_pend_q;
	status_t           res_status_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [WORD_W-1:0] out_value_q;
	logic              out_last_q;

	logic [LEN_W-1:0]  len_c;
	logic [IDX_W-1:0]  head_nx, tail_nx, ptr_nx;
	logic              accept, out_free, is_full;
	logic              out_load;
	logic              mem_we, mem_re;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_rdata;
	logic              show_stop;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
			input logic [LEN_W-1:0] len);
		logic [CW-1:0] inc;
		inc = CW'(i) + CW'(1);
		if (inc >= CW'(len)) begin
			return '0;
		end
		return inc[IDX_W-1:0];
	endfunction

	// Clamp the length register to 1 .. CAP.
	always_comb begin
		if (length_q == '0) begin
			len_c = LEN_W'(1);
		end else if (length_q > LEN_W'(CAP)) begin
			len_c = LEN_W'(CAP);
		end else begin
			len_c = length_q;
		end
	end

	assign head_nx  = next_idx(head_q, len_c);
	assign tail_nx  = next_idx(tail_q, len_c);
	assign ptr_nx   = next_idx(ptr_q, len_c);
	assign is_full  = (tail_nx == head_q);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ((state_q == S_RES) || (state_q == S_DATA)) && out_free;

	// Final word of a show: reached the tail or emitted a full queue's worth.
	assign show_stop = (ptr_q == tail_q) ||
		((CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(len_c));

	assign mem_we    = accept && (action == ACT_PUSH) && (empty_q || !is_full);
	assign mem_waddr = empty_q ? '0 : tail_nx;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = head_q;
		if (accept && !empty_q && (action == ACT_POP || action == ACT_SHOW)) begin
			mem_re    = 1'b1;
			mem_raddr = head_q;
		end else if (state_q == S_DATA && out_free && !last_pend_q) begin
			mem_re    = 1'b1;
			mem_raddr = ptr_q;
		end
	end

	cqb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(push_value),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			ptr_q        <= '0;
			empty_q      <= 1'b1;
			length_q     <= LEN_RESET;
			cnt_q        <= '0;
			last_pend_q  <= 1'b0;
			res_status_q <= ST_EMPTY;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_EMPTY;
			out_value_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// Load a new word or hold the current one until taken.
			out_valid_q <= out_load || (out_valid_q && !out_ready);

			// Length changes only on an empty queue.
			if (cfg_we && empty_q) begin
				length_q <= cfg_wdata;
				head_q   <= '0;
				tail_q   <= '0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (action)
							ACT_PUSH: begin
								state_q      <= S_RES;
								res_status_q <= ST_PUSHED;
								if (empty_q) begin
									head_q  <= '0;
									tail_q  <= '0;
									empty_q <= 1'b0;
								end else if (is_full) begin
									res_status_q <= ST_FULL;
								end else begin
									tail_q <= tail_nx;
								end
							end
							ACT_POP: begin
								if (empty_q) begin
									state_q      <= S_RES;
									res_status_q <= ST_EMPTY;
								end else begin
									state_q     <= S_DATA;
									last_pend_q <= 1'b1;
									if (head_q == tail_q) begin
										head_q  <= '0;
										tail_q  <= '0;
										empty_q <= 1'b1;
									end else begin
										head_q <= head_nx;
									end
								end
							end
							ACT_SHOW: begin
								if (empty_q) begin
									state_q      <= S_RES;
									res_status_q <= ST_EMPTY;
								end else begin
									state_q     <= S_DATA;
									last_pend_q <= (head_q == tail_q) || (len_c == LEN_W'(1));
									ptr_q       <= head_nx;
									cnt_q       <= CNT_W'(1);
								end
							end
							ACT_NONE: begin
								// Drop the request: no result.
							end
							default: begin
							end
						endcase
					end
				end
				S_RES: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_value_q  <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_DATA: begin
					if (out_free) begin
						out_status_q <= ST_VALUE;
						out_value_q  <= mem_rdata;
						out_last_q   <= last_pend_q;
						if (last_pend_q) begin
							state_q <= S_IDLE;
						end else begin
							// Next read was issued this cycle; advance the walk.
							last_pend_q <= show_stop;
							ptr_q       <= ptr_nx;
							cnt_q       <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign value     = out_value_q;
	assign last      = out_last_q;

	`CQB_ASSERT_ALWAYS(a_empty_ptrs_zero, !empty_q || (head_q == '0 && tail_q == '0))
	`CQB_ASSERT_ALWAYS(a_ptrs_in_range,
		(CW'(head_q) < CW'(len_c)) && (CW'(tail_q) < CW'(len_c)))
	`CQB_ASSERT_NEXT(a_last_word_ends,
		state_q == S_DATA && out_free && last_pend_q,
		state_q == S_IDLE && out_valid_q && out_last_q)

endmodule

`default_nettype wire

// ===== dv/circular_queue_buffer_test.sv =====
`default_nettype none

module circular_queue_buffer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cqb_pkg::*;

	localparam int DEPTH       = 16;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int DRAIN_TAIL  = 8;
	localparam int HOLD_CYCLES = 160;
	localparam int RX_OPEN     = 0;
	localparam int RX_PATTERN  = 1;
	localparam int RX_RANDOM   = 2;
	localparam int LEN_ROW     = 4;

	typedef struct {
		status_t                    code;
		logic signed [WORD_W-1:0]   word;
		logic                       last_flag;
	} result_word_t;

	typedef struct {
		action_t                    act;
		logic signed [WORD_W-1:0]   word;
		bit                         typed_row;
		status_t                    code;
		logic signed [WORD_W-1:0]   answer;
	} drive_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic signed [WORD_W-1:0] push_value;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic signed [WORD_W-1:0] value;
	logic last;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	// queue model
	logic signed [WORD_W-1:0] slot_copy [DEPTH];
	logic [IDX_W-1:0] head_at;
	logic [IDX_W-1:0] tail_at;
	logic queue_drained;
	logic [LEN_W-1:0] length_reg;

	result_word_t fresh_words [$];
	result_word_t expected_words [$];
	result_word_t want;
	drive_row_t directed_rows [19];
	int errors = 0;

	int rx_mode = RX_OPEN;
	logic hold_pending = 1'b0;
	logic [15:0] stall_pattern = 16'b1101_1011_1001_0111;
	int rx_phase = 0;

	circular_queue_buffer #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.value(value),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int slots_in_use();
		int n;
		int cap;
		cap = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
		n = int'(length_reg);
		if (n < 1) n = 1;
		if (n > cap) n = cap;
		return n;
	endfunction

	function automatic logic [IDX_W-1:0] step_index(logic [IDX_W-1:0] i, int n);
		return (int'(i) + 1 >= n) ? '0 : i + 1'b1;
	endfunction

	function automatic void queue_result(status_t code, logic signed [WORD_W-1:0] word,
			logic last_flag);
		result_word_t r;
		r.code = code;
		r.word = word;
		r.last_flag = last_flag;
		fresh_words.push_back(r);
	endfunction

	function automatic void model_request(action_t act, logic signed [WORD_W-1:0] w);
		int n;
		int k;
		logic [IDX_W-1:0] i;
		logic done;
		n = slots_in_use();
		fresh_words.delete();
		if (int'(head_at) >= n) head_at = '0;
		if (int'(tail_at) >= n) tail_at = '0;
		case (act)
			ACT_PUSH: begin
				if (queue_drained) begin
					head_at = '0;
					tail_at = '0;
					slot_copy[0] = w;
					queue_drained = 1'b0;
					queue_result(ST_PUSHED, '0, 1'b1);
				end else if (step_index(tail_at, n) == head_at) begin
					queue_result(ST_FULL, '0, 1'b1);
				end else begin
					tail_at = step_index(tail_at, n);
					slot_copy[tail_at] = w;
					queue_result(ST_PUSHED, '0, 1'b1);
				end
			end
			ACT_POP: begin
				if (queue_drained) begin
					queue_result(ST_EMPTY, '0, 1'b1);
				end else begin
					queue_result(ST_VALUE, slot_copy[head_at], 1'b1);
					if (head_at == tail_at) begin
						head_at = '0;
						tail_at = '0;
						queue_drained = 1'b1;
					end else begin
						head_at = step_index(head_at, n);
					end
				end
			end
			ACT_SHOW: begin
				if (queue_drained) begin
					queue_result(ST_EMPTY, '0, 1'b1);
				end else begin
					i = head_at;
					k = 0;
					done = 1'b0;
					while (!done && k < MAX_RESULTS) begin
						done = (i == tail_at) || (k + 1 >= n);
						queue_result(ST_VALUE, slot_copy[i], done);
						k++;
						i = step_index(i, n);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void model_length(logic [LEN_W-1:0] v);
		// length only changes while the queue is empty
		if (!queue_drained) return;
		length_reg = v;
		head_at = '0;
		tail_at = '0;
	endfunction

	function automatic action_t pick_action(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct) return ACT_PUSH;
		if (r < push_pct + (95 - push_pct) * 2 / 3) return ACT_POP;
		if (r < 96) return ACT_SHOW;
		return ACT_NONE;
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input action_t act, input logic signed [WORD_W-1:0] w,
			input bit typed_row, input status_t code, input logic signed [WORD_W-1:0] answer);
		result_word_t r;
		in_valid <= 1'b1;
		action <= act;
		push_value <= w;
		do @(posedge clk); while (!in_ready);
		model_request(act, w);
		if (typed_row) begin
			r.code = code;
			r.word = answer;
			r.last_flag = 1'b1;
			expected_words.push_back(r);
		end else begin
			foreach (fresh_words[j]) expected_words.push_back(fresh_words[j]);
		end
	endtask

	task automatic rest(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		// a dropped request may still be in flight
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_length(v);
	endtask

	task automatic empty_queue();
		while (!queue_drained) send_word(ACT_POP, pick_word(), 1'b0, ST_PUSHED, '0);
	endtask

	task automatic run_phase(input int items, input int push_pct, input bit gapless);
		int burst;
		int sent;
		action_t act;
		burst = 0;
		sent = 0;
		while (sent < items) begin
			if (!gapless && burst == 0) begin
				rest($urandom_range(0, 6));
				burst = $urandom_range(1, 12);
			end
			act = pick_action(push_pct);
			send_word(act, pick_word(), 1'b0, ST_PUSHED, '0);
			if (act != ACT_NONE) sent++;
			if (burst > 0) burst--;
		end
	endtask

	// receiver
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending <= 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case (rx_mode)
					RX_PATTERN: out_ready <= stall_pattern[rx_phase % 16];
					RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
					default: out_ready <= 1'b1;
				endcase
				rx_phase++;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word: status %0d value %h last %b",
					status, value, last);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (status !== want.code) begin
					$error("status: expected %0d, got %0d", want.code, status);
					errors++;
				end
				if (value !== want.word) begin
					$error("value: expected %h, got %h", want.word, value);
					errors++;
				end
				if (last !== want.last_flag) begin
					$error("last: expected %b, got %b", want.last_flag, last);
					errors++;
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [LEN_W-1:0] lengths [9];
		int p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_PUSH;
		push_value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		head_at = '0;
		tail_at = '0;
		queue_drained = 1'b1;
		length_reg = LEN_RESET;
		lengths = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd2, 5'd7, 5'd17, 5'd4, 5'd12};
		directed_rows = '{
			'{ACT_POP,  32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
			'{ACT_SHOW, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
			'{ACT_PUSH, 32'h1357_9BDF, 1'b1, ST_PUSHED, 32'h0000_0000},
			'{ACT_POP,  32'h0000_0000, 1'b1, ST_VALUE,  32'h1357_9BDF},
			'{ACT_PUSH, 32'h8000_0000, 1'b1, ST_PUSHED, 32'h0000_0000},
			'{ACT_PUSH, 32'h7FFF_FFFF, 1'b1, ST_PUSHED, 32'h0000_0000},
			'{ACT_PUSH, 32'hFFFF_FFFF, 1'b1, ST_PUSHED, 32'h0000_0000},
			'{ACT_PUSH, 32'h0000_0000, 1'b1, ST_FULL,   32'h0000_0000},
			'{ACT_SHOW, 32'h0000_0000, 1'b0, ST_VALUE,  32'h0000_0000},
			'{ACT_POP,  32'h0000_0000, 1'b1, ST_VALUE,  32'h8000_0000},
			'{ACT_PUSH, 32'h0000_0001, 1'b1, ST_PUSHED, 32'h0000_0000},
			'{ACT_SHOW, 32'h0000_0000, 1'b0, ST_VALUE,  32'h0000_0000},
			'{ACT_NONE, 32'hDEAD_BEEF, 1'b0, ST_PUSHED, 32'h0000_0000},
			'{ACT_POP,  32'h0000_0000, 1'b1, ST_VALUE,  32'h7FFF_FFFF},
			'{ACT_POP,  32'h0000_0000, 1'b1, ST_VALUE,  32'hFFFF_FFFF},
			'{ACT_POP,  32'h0000_0000, 1'b1, ST_VALUE,  32'h0000_0001},
			'{ACT_POP,  32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
			'{ACT_SHOW, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0000_0000},
			'{ACT_NONE, 32'h0000_0000, 1'b0, ST_PUSHED, 32'h0000_0000}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first rows run at the reset length, the rest on a three-slot ring
		foreach (directed_rows[r]) begin
			if (r == LEN_ROW) write_length(5'd3);
			rest($urandom_range(0, 2));
			send_word(directed_rows[r].act, directed_rows[r].word, directed_rows[r].typed_row,
				directed_rows[r].code, directed_rows[r].answer);
		end
		settle();

		for (p = 0; p < 9; p++) begin
			rx_mode <= p % 3;
			if (p == 1) begin
				// length write on a non-empty queue must be dropped
				send_word(ACT_PUSH, pick_word(), 1'b0, ST_PUSHED, '0);
				send_word(ACT_PUSH, pick_word(), 1'b0, ST_PUSHED, '0);
				write_length(5'd9);
			end
			empty_queue();
			write_length(lengths[p]);
			if (p == 4) begin
				// stall the output long enough to back up the input
				hold_pending <= 1'b1;
				run_phase(40, 70, 1'b1);
			end
			run_phase(38, $urandom_range(40, 65), (p % 4) == 2);
		end

		settle();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/cqb_pkg.sv
src/cqb_ram.sv
src/circular_queue_buffer.sv
dv/circular_queue_buffer_test.sv
